/* src/ubdc_pkg.sv */
// shared types and constants for the uart baud divisor calculator
package ubdc_pkg;

	localparam int BAUD_W = 24;
	localparam int CLK_W = 27;
	localparam int DIV_W = 16;
	localparam int STAT_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam int NUM_W = 32;
	localparam int DEN_W = 26;
	localparam int MANT_W = 26;
	localparam int REM_W = 7;
	localparam int FRAC_W = 4;
	localparam int VSUM_W = 11;

	localparam int MANTISSA_BITS = 12;
	localparam logic [MANT_W:0] MANT_FIT = (MANT_W + 1)'((64'd1 << (DIV_W - FRAC_W)) - 64'd1);

	localparam logic [NUM_W-1:0] CLK_SCALE = 32'd25;
	localparam logic [NUM_W-1:0] PCT = 32'd100;
	localparam logic [VSUM_W-1:0] HALF_PCT = 11'd50;
	localparam logic [NUM_W-1:0] PCT_RECIP = 32'h51EB851F;
	localparam int PCT_RECIP_SHIFT = 37;
	localparam logic [23:0] FRAC_RECIP = 24'd5243;
	localparam int FRAC_RECIP_SHIFT = 19;
	localparam logic [FRAC_W:0] STEPS_8X = 5'd8;
	localparam logic [FRAC_W:0] STEPS_16X = 5'd16;

	localparam logic [CLK_W-1:0] CLK_RESET = 27'd16000000;

	localparam logic [CFG_IDX_W-1:0] REG_SLOW_CLK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_CLK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OVER8 = 2'd2;

	localparam logic [STAT_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_ZERO_BAUD = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_SATURATED = 2'd2;

	localparam logic [DIV_W-1:0] DIVISOR_SAT = 16'hFFFF;

	typedef struct packed {
		logic [BAUD_W-1:0] baud;
		logic on_fast_bus;
	} in_t;

	typedef struct packed {
		logic [DIV_W-1:0] divisor;
		logic [STAT_W-1:0] status;
	} out_t;

	typedef struct packed {
		logic zero_baud;
		logic over8;
	} side_t;

endpackage

/* src/ubdc_div.sv */
// pipelined restoring divider, one quotient bit per stage
module ubdc_div (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  logic [ubdc_pkg::NUM_W-1:0] num,
	input  logic [ubdc_pkg::DEN_W-1:0] den,
	input  ubdc_pkg::side_t in_side,
	output logic out_valid,
	output logic [ubdc_pkg::NUM_W-1:0] quot,
	output ubdc_pkg::side_t out_side
);
	import ubdc_pkg::*;

	logic vld_s [NUM_W];
	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] num_s [NUM_W];
	logic [NUM_W-1:0] quo_s [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];
	side_t side_s [NUM_W];

	genvar i;
	for (i = 0; i < NUM_W; i++) begin : g_stage
		logic vld_p;
		logic [DEN_W-1:0] rem_p;
		logic [NUM_W-1:0] num_p;
		logic [NUM_W-1:0] quo_p;
		logic [DEN_W-1:0] den_p;
		side_t side_p;
		logic [DEN_W:0] shifted;
		logic [DEN_W:0] diff;
		logic ge;

		if (i == 0) begin : g_first
			assign vld_p = in_valid;
			assign rem_p = '0;
			assign num_p = num;
			assign quo_p = '0;
			assign den_p = den;
			assign side_p = in_side;
		end else begin : g_next
			assign vld_p = vld_s[i-1];
			assign rem_p = rem_s[i-1];
			assign num_p = num_s[i-1];
			assign quo_p = quo_s[i-1];
			assign den_p = den_s[i-1];
			assign side_p = side_s[i-1];
		end

		assign shifted = {rem_p, num_p[NUM_W-1]};
		assign ge = shifted >= {1'b0, den_p};
		assign diff = shifted - {1'b0, den_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i] <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
				num_s[i] <= {num_p[NUM_W-2:0], 1'b0};
				quo_s[i] <= {quo_p[NUM_W-2:0], ge};
				den_s[i] <= den_p;
				side_s[i] <= side_p;
			end
		end
	end

	assign out_valid = vld_s[NUM_W-1];
	assign quot = quo_s[NUM_W-1];
	assign out_side = side_s[NUM_W-1];

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NUM_W-1] && !side_s[NUM_W-1].zero_baud |-> rem_s[NUM_W-1] < den_s[NUM_W-1])
		else $error("divider remainder not below divisor");
	a_zero_den_flag: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] && den_s[0] == '0 |-> side_s[0].zero_baud)
		else $error("zero divisor without zero baud flag");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && vld_s[NUM_W-1] |=> vld_s[NUM_W-1] && $stable(quo_s[NUM_W-1]))
		else $error("divider output changed during stall");
endmodule

/* src/ubdc_post.sv */
// mantissa split, fraction rounding, carry and saturation stages
module ubdc_post #(
	parameter int MANTISSA_BITS = ubdc_pkg::MANTISSA_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  logic [ubdc_pkg::NUM_W-1:0] quot,
	input  ubdc_pkg::side_t in_side,
	output logic out_valid,
	output ubdc_pkg::out_t out_data
);
	import ubdc_pkg::*;

	localparam logic [MANT_W:0] MANT_LIMIT = (MANT_W + 1)'((64'd1 << MANTISSA_BITS) - 64'd1);

	logic [2*NUM_W-1:0] recip_prod;
	logic [NUM_W-1:0] mant_x100;
	logic [VSUM_W-1:0] vsum;
	logic [23:0] frac_prod;
	logic [FRAC_W:0] steps;
	logic carry;
	logic [MANT_W:0] mant_adj;
	logic ovf;
	out_t res;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic [MANT_W-1:0] mant_s1, mant_s2, mant_s3;
	logic [NUM_W-1:0] scaled_s1;
	logic [REM_W-1:0] rem_s2;
	logic [FRAC_W:0] frac_s3;
	side_t side_s1, side_s2, side_s3, side_s4;
	out_t data_s4;

	assign recip_prod = 64'(quot) * 64'(PCT_RECIP);
	assign mant_x100 = 32'(mant_s1) * PCT;
	assign vsum = (side_s2.over8 ? (VSUM_W'(rem_s2) << 3) : (VSUM_W'(rem_s2) << 4)) + HALF_PCT;
	assign frac_prod = 24'(vsum) * FRAC_RECIP;

	assign steps = side_s3.over8 ? STEPS_8X : STEPS_16X;
	assign carry = frac_s3 >= steps;
	assign mant_adj = (MANT_W + 1)'(mant_s3) + (MANT_W + 1)'(carry);
	assign ovf = (mant_adj > MANT_LIMIT) || (mant_adj > MANT_FIT);

	always_comb begin
		if (side_s3.zero_baud) begin
			res.divisor = '0;
			res.status = STATUS_ZERO_BAUD;
		end else if (ovf) begin
			res.divisor = DIVISOR_SAT;
			res.status = STATUS_SATURATED;
		end else begin
			res.divisor = {mant_adj[DIV_W-FRAC_W-1:0], carry ? {FRAC_W{1'b0}} : frac_s3[FRAC_W-1:0]};
			res.status = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mant_s1 <= recip_prod[PCT_RECIP_SHIFT +: MANT_W];
			scaled_s1 <= quot;
			side_s1 <= in_side;
			mant_s2 <= mant_s1;
			rem_s2 <= REM_W'(scaled_s1 - mant_x100);
			side_s2 <= side_s1;
			mant_s3 <= mant_s2;
			frac_s3 <= frac_prod[FRAC_RECIP_SHIFT +: FRAC_W + 1];
			side_s3 <= side_s2;
			data_s4 <= res;
			side_s4 <= side_s3;
		end
	end

	assign out_valid = vld_s4;
	assign out_data = data_s4;

	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && side_s4.zero_baud |-> data_s4.divisor == '0 && data_s4.status == STATUS_ZERO_BAUD)
		else $error("zero baud word not cleared");
	a_sat_word: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && data_s4.status == STATUS_SATURATED |-> data_s4.divisor == DIVISOR_SAT)
		else $error("saturated word without full divisor");
	a_over8_frac: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && side_s4.over8 && data_s4.status == STATUS_OK |-> !data_s4.divisor[FRAC_W-1])
		else $error("8x fraction wider than three bits");
endmodule

/* src/uart_baud_divisor_calc.sv */
// uart fractional baud divisor calculator, top level
//
//  channel  direction  handshake             word
//  in       input      in_valid/in_ready     baud, on_fast_bus
//  out      output     out_valid/out_ready   divisor, status
//  cfg      input      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// one word per cycle unless a word is waiting at the output
// each word passes through the prep stage, the 32-stage divider and four post stages
// reset clears all valid bits and loads the register defaults
// a word waiting at the output holds the whole pipeline; in_ready drops
// configuration writes are always taken
module uart_baud_divisor_calc #(
	parameter int MANTISSA_BITS = ubdc_pkg::MANTISSA_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ubdc_pkg::in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output ubdc_pkg::out_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ubdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ubdc_pkg::CLK_W-1:0] cfg_data
);
	import ubdc_pkg::*;

	logic [CLK_W-1:0] slow_clk_q, fast_clk_q;
	logic over8_q;
	logic adv;
	logic [CLK_W-1:0] pclk;

	logic vld_s1;
	logic [NUM_W-1:0] num_s1;
	logic [DEN_W-1:0] den_s1;
	side_t side_s1;

	logic div_valid;
	logic [NUM_W-1:0] div_quot;
	side_t div_side;

	assign adv = !out_valid || out_ready;
	assign in_ready = adv;
	assign cfg_ready = 1'b1;
	assign pclk = in_data.on_fast_bus ? fast_clk_q : slow_clk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_clk_q <= CLK_RESET;
			fast_clk_q <= CLK_RESET;
			over8_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SLOW_CLK: slow_clk_q <= cfg_data;
				REG_FAST_CLK: fast_clk_q <= cfg_data;
				REG_OVER8: over8_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= NUM_W'(pclk) * CLK_SCALE;
			den_s1 <= over8_q ? (DEN_W'(in_data.baud) << 1) : (DEN_W'(in_data.baud) << 2);
			side_s1.zero_baud <= in_data.baud == '0;
			side_s1.over8 <= over8_q;
		end
	end

	ubdc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(vld_s1),
		.num(num_s1),
		.den(den_s1),
		.in_side(side_s1),
		.out_valid(div_valid),
		.quot(div_quot),
		.out_side(div_side)
	);

	ubdc_post #(
		.MANTISSA_BITS(MANTISSA_BITS)
	) u_post (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(div_valid),
		.quot(div_quot),
		.in_side(div_side),
		.out_valid(out_valid),
		.out_data(out_data)
	);

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word lost during stall");
	a_stall_front: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && vld_s1 |=> vld_s1 && $stable(num_s1) && $stable(den_s1))
		else $error("front stage changed during stall");
	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !side_s1.zero_baud |-> den_s1 != '0)
		else $error("nonzero baud gave zero divisor");
endmodule

/* tb/uart_baud_divisor_calc_tb.sv */
// testbench for the uart baud divisor calculator: directed table plus random words, self-checking
`timescale 1ns / 1ps

module uart_baud_divisor_calc_tb;
	import ubdc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES = 6;
	localparam int WORDS_PER_PHASE = 85;

	typedef struct packed {
		bit is_cfg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CLK_W-1:0] reg_val;
		in_t word;
		bit typed;
		out_t want;
	} step_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CLK_W-1:0] cfg_data;

	logic [CLK_W-1:0] slow_clk_hz;
	logic [CLK_W-1:0] fast_clk_hz;
	bit over8_mode;

	out_t pending_divisors[$];
	out_t want_word;
	step_t dir_rows[$];
	int unsigned mismatch_count;
	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_req;

	int unsigned std_bauds[12] = '{300, 1200, 2400, 4800, 9600, 19200, 38400, 57600,
		115200, 230400, 460800, 921600};

	uart_baud_divisor_calc dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic out_t predict_divisor(in_t w);
		longint unsigned pclk, scaled, mant, rem, frac, steps, limit;
		out_t r;
		if (w.baud == '0) begin
			r.divisor = '0;
			r.status = STATUS_ZERO_BAUD;
			return r;
		end
		pclk = w.on_fast_bus ? fast_clk_hz : slow_clk_hz;
		steps = over8_mode ? 8 : 16;
		scaled = (25 * pclk) / ((over8_mode ? 2 : 4) * longint'(w.baud));
		mant = scaled / 100;
		rem = scaled - mant * 100;
		frac = (rem * steps + 50) / 100;
		if (frac >= steps) begin
			frac = 0;
			mant = mant + 1;
		end
		limit = (64'd1 << MANTISSA_BITS) - 1;
		if (mant > limit || ((mant << 4) | frac) > 64'hFFFF) begin
			r.divisor = DIVISOR_SAT;
			r.status = STATUS_SATURATED;
		end else begin
			r.divisor = DIV_W'((mant << 4) | frac);
			r.status = STATUS_OK;
		end
		return r;
	endfunction

	function automatic step_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CLK_W-1:0] val);
		step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.reg_idx = idx;
		s.reg_val = val;
		return s;
	endfunction

	function automatic step_t item_row(int unsigned baud, bit fast);
		step_t s;
		s = '0;
		s.word.baud = BAUD_W'(baud);
		s.word.on_fast_bus = fast;
		return s;
	endfunction

	function automatic step_t checked_row(int unsigned baud, bit fast,
			logic [DIV_W-1:0] div, logic [STAT_W-1:0] stat);
		step_t s;
		s = item_row(baud, fast);
		s.typed = 1'b1;
		s.want.divisor = div;
		s.want.status = stat;
		return s;
	endfunction

	function automatic logic [CLK_W-1:0] pick_clock();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CLK_W'(1);
			2: return '1;
			3: return CLK_W'(100000000);
			4: return CLK_W'($urandom);
			default: return CLK_W'($urandom_range(1000000, 100000000));
		endcase
	endfunction

	function automatic in_t pick_word();
		in_t w;
		w.on_fast_bus = 1'($urandom);
		case ($urandom_range(0, 9))
			0: w.baud = '0;
			1: w.baud = BAUD_W'($urandom);
			2: w.baud = '1;
			3, 4, 5: w.baud = BAUD_W'(std_bauds[$urandom_range(0, 11)]);
			6, 7: w.baud = BAUD_W'($urandom_range(1, 5000));
			default: w.baud = BAUD_W'($urandom_range(1, 12500000));
		endcase
		return w;
	endfunction

	task automatic report_mismatch(string what, out_t got, out_t want);
		$display("mismatch at %0t: %s, got divisor %h status %0d, want divisor %h status %0d",
			$realtime, what, got.divisor, got.status, want.divisor, want.status);
		mismatch_count++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CLK_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SLOW_CLK: slow_clk_hz = val;
			REG_FAST_CLK: fast_clk_hz = val;
			REG_OVER8: over8_mode = val[0];
			default: ;
		endcase
	endtask

	task automatic send_item(in_t w, bit typed, out_t want);
		cfg_valid <= 1'b0;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		pending_divisors.push_back(typed ? want : predict_divisor(w));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_divisors.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random backpressure, or a long hold-off on request
	initial begin
		out_ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_divisors.size() == 0) begin
				report_mismatch("unexpected word", out_data, '0);
			end else begin
				want_word = pending_divisors.pop_front();
				if (out_data.divisor !== want_word.divisor)
					report_mismatch("divisor", out_data, want_word);
				if (out_data.status !== want_word.status)
					report_mismatch("status", out_data, want_word);
			end
		end
	end

	initial begin
		#400000;
		$display("[uart_baud_divisor_calc] ERROR");
		$finish;
	end

	initial begin
		int i;
		int p;
		step_t row;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		mismatch_count = 0;
		tx_idle_pct = 32;
		rx_idle_pct = 32;
		hold_req = 1'b0;
		slow_clk_hz = CLK_RESET;
		fast_clk_hz = CLK_RESET;
		over8_mode = 1'b0;

		// reset defaults, zero baud, saturation, rounding carry, zero clock
		dir_rows.push_back(checked_row(9600, 1'b0, 16'h0683, STATUS_OK));
		dir_rows.push_back(checked_row(9600, 1'b1, 16'h0683, STATUS_OK));
		dir_rows.push_back(checked_row(0, 1'b0, 16'h0000, STATUS_ZERO_BAUD));
		dir_rows.push_back(checked_row(0, 1'b1, 16'h0000, STATUS_ZERO_BAUD));
		dir_rows.push_back(checked_row(1, 1'b0, DIVISOR_SAT, STATUS_SATURATED));
		dir_rows.push_back(item_row(24'hFFFFFF, 1'b1));
		dir_rows.push_back(item_row(91150, 1'b0));
		dir_rows.push_back(item_row(244, 1'b0));
		dir_rows.push_back(item_row(245, 1'b0));
		dir_rows.push_back(cfg_row(REG_OVER8, 27'd1));
		dir_rows.push_back(item_row(182648, 1'b0));
		dir_rows.push_back(item_row(115200, 1'b1));
		dir_rows.push_back(checked_row(1, 1'b1, DIVISOR_SAT, STATUS_SATURATED));
		dir_rows.push_back(cfg_row(REG_SLOW_CLK, 27'd0));
		dir_rows.push_back(cfg_row(REG_FAST_CLK, 27'h7FFFFFF));
		dir_rows.push_back(checked_row(9600, 1'b0, 16'h0000, STATUS_OK));
		dir_rows.push_back(item_row(24'hFFFFFF, 1'b1));
		dir_rows.push_back(checked_row(1, 1'b1, DIVISOR_SAT, STATUS_SATURATED));
		dir_rows.push_back(cfg_row(REG_UNUSED, 27'h5A5A5A5));
		dir_rows.push_back(item_row(24'h800000, 1'b1));
		dir_rows.push_back(cfg_row(REG_SLOW_CLK, 27'd1));
		dir_rows.push_back(checked_row(24'hFFFFFF, 1'b0, 16'h0000, STATUS_OK));
		dir_rows.push_back(cfg_row(REG_OVER8, 27'h7FFFFFE));
		dir_rows.push_back(item_row(12500000, 1'b1));
		dir_rows.push_back(cfg_row(REG_FAST_CLK, 27'd100000000));
		dir_rows.push_back(item_row(12500000, 1'b1));
		dir_rows.push_back(checked_row(0, 1'b1, 16'h0000, STATUS_ZERO_BAUD));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.is_cfg) begin
				drain_results();
				write_reg(row.reg_idx, row.reg_val);
			end else begin
				send_item(row.word, row.typed, row.want);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			drain_results();
			write_reg(REG_SLOW_CLK, pick_clock());
			write_reg(REG_FAST_CLK, pick_clock());
			write_reg(REG_OVER8, {26'($urandom), 1'(p % 2)});
			if (p == 3)
				write_reg(REG_UNUSED, CLK_W'($urandom));
			tx_idle_pct = (p == 0) ? 0 : 32;
			rx_idle_pct = (p == 0) ? 0 : 32;
			// receiver holds off while words keep coming, so the pipeline backs up
			if (p == 1)
				hold_req = 1'b1;
			for (i = 0; i < WORDS_PER_PHASE; i++) begin
				if (p == 2 && i == WORDS_PER_PHASE / 2)
					drain_results();
				send_item(pick_word(), 1'b0, '0);
			end
		end

		drain_results();
		repeat (50) @(posedge clk);
		if (mismatch_count == 0)
			$display("[uart_baud_divisor_calc] OK");
		else
			$display("[uart_baud_divisor_calc] ERROR");
		$finish;
	end

endmodule
